>>> rtl/lpsc_pkg.sv
// lpsc_pkg: shared types and constants for the length-prefixed to start-code converter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package lpsc_pkg;

  // prefix length register
  localparam int unsigned LenBytesW     = 3;
  localparam logic [LenBytesW-1:0] LenBytesMin   = 3'd1;
  localparam logic [LenBytesW-1:0] LenBytesMax   = 3'd4;
  localparam logic [LenBytesW-1:0] LenBytesReset = 3'd4;

  // start code bytes
  localparam logic [7:0] StartZeroByte = 8'h00;
  localparam logic [7:0] StartOneByte  = 8'h01;
  localparam logic [7:0] ErrorByte     = 8'h00;

  // input word
  typedef struct packed {
    logic [7:0] in_byte;
    logic       packet_last;
  } lpsc_in_t;

  // output word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       packet_end;
    logic       packet_error;
  } lpsc_out_t;

  // what one accepted input word turns into
  typedef enum logic [1:0] {
    BurstPayload = 2'd0,
    BurstError   = 2'd1,
    BurstStart3  = 2'd2,
    BurstStart4  = 2'd3
  } burst_kind_e;

  typedef struct packed {
    burst_kind_e kind;
    logic [7:0]  data;
    logic        pkt_last;
  } lpsc_burst_t;

endpackage

>>> rtl/length_prefixed_to_start_code_nal.sv
// length_prefixed_to_start_code_nal: strips unit length prefixes, inserts start codes
// a taken word's burst is registered in the emit queue, whose head drives the output
// throughput: one payload byte per cycle unless the two-burst queue is full;
//   a prefix end adds a 3 or 4 word start code, sequenced at one word per ready cycle
// reset: async active low, length register returns to 4, packet state to start of packet
// depends on lpsc_pkg, lpsc_parse, lpsc_emit
`timescale 1ns / 1ps

module length_prefixed_to_start_code_nal (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  lpsc_pkg::lpsc_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output lpsc_pkg::lpsc_out_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lpsc_pkg::LenBytesW-1:0]  cfg_data_i
);
  import lpsc_pkg::*;

  logic [LenBytesW-1:0] len_bytes_q;
  logic                 accept;
  logic                 push;
  logic                 full;
  lpsc_burst_t          burst;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full;
  assign accept      = in_valid_i && in_ready_o;

  // prefix length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_bytes_q <= LenBytesReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      len_bytes_q <= cfg_data_i;
    end
  end

  lpsc_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_data_i   (in_data_i),
    .len_bytes_i (len_bytes_q),
    .push_o      (push),
    .burst_o     (burst)
  );

  lpsc_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push && accept),
    .burst_i     (burst),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  // an error word always closes the packet on its own
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.packet_error) |->
      (out_data_o.run_last && out_data_o.packet_end))
    else $error("error word without packet end");
`endif

endmodule

>>> rtl/lpsc_parse.sv
// lpsc_parse: per-word prefix/payload tracking, decides the burst each input word causes
// depends on lpsc_pkg
`timescale 1ns / 1ps

module lpsc_parse (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  lpsc_pkg::lpsc_in_t                in_data_i,
  input  logic [lpsc_pkg::LenBytesW-1:0]    len_bytes_i,
  output logic                              push_o,
  output lpsc_pkg::lpsc_burst_t             burst_o
);
  import lpsc_pkg::*;

  logic        in_payload_q, in_payload_d;
  logic [1:0]  prefix_count_q, prefix_count_d;
  logic [31:0] length_accum_q, length_accum_d;
  logic [31:0] payload_left_q, payload_left_d;
  logic        first_unit_q, first_unit_d;
  logic        error_seen_q, error_seen_d;

  logic [2:0]  lb;
  logic [31:0] acc_next;
  logic [2:0]  cnt_next;
  logic [31:0] left_next;
  logic        fail;
  logic        clear;
  logic        last;

  // clamp the register into 1..4
  always_comb begin
    if (len_bytes_i < LenBytesMin) begin
      lb = LenBytesMin;
    end else if (len_bytes_i > LenBytesMax) begin
      lb = LenBytesMax;
    end else begin
      lb = len_bytes_i;
    end
  end

  assign last      = in_data_i.packet_last;
  assign acc_next  = {length_accum_q[23:0], in_data_i.in_byte};
  assign cnt_next  = {1'b0, prefix_count_q} + 3'd1;
  assign left_next = payload_left_q - 32'd1;

  // next state and burst selection
  always_comb begin
    in_payload_d   = in_payload_q;
    prefix_count_d = prefix_count_q;
    length_accum_d = length_accum_q;
    payload_left_d = payload_left_q;
    first_unit_d   = first_unit_q;
    error_seen_d   = error_seen_q;
    fail           = 1'b0;
    push_o         = 1'b0;
    burst_o.kind     = BurstPayload;
    burst_o.data     = in_data_i.in_byte;
    burst_o.pkt_last = last;

    if (error_seen_q) begin
      fail = 1'b1;
    end else if (in_payload_q) begin
      if (last && (left_next != 32'd0)) begin
        fail = 1'b1;
      end else begin
        push_o         = 1'b1;
        payload_left_d = left_next;
        if (left_next == 32'd0) begin
          in_payload_d   = 1'b0;
          prefix_count_d = 2'd0;
          length_accum_d = 32'd0;
        end
      end
    end else if (cnt_next < lb) begin
      // still collecting prefix bytes
      prefix_count_d = cnt_next[1:0];
      length_accum_d = acc_next;
      fail           = last;
    end else if ((lb == LenBytesMax) && acc_next[31]) begin
      fail = 1'b1;
    end else if ((acc_next != 32'd0) && last) begin
      fail = 1'b1;
    end else begin
      // prefix complete: start code replaces it
      push_o         = 1'b1;
      burst_o.kind   = first_unit_q ? BurstStart4 : BurstStart3;
      first_unit_d   = 1'b0;
      prefix_count_d = 2'd0;
      length_accum_d = 32'd0;
      if (acc_next != 32'd0) begin
        in_payload_d   = 1'b1;
        payload_left_d = acc_next;
      end
    end

    // malformed packet: swallow until the last word
    if (fail) begin
      in_payload_d   = 1'b0;
      prefix_count_d = 2'd0;
      length_accum_d = 32'd0;
      payload_left_d = 32'd0;
      error_seen_d   = 1'b1;
      if (last) begin
        push_o       = 1'b1;
        burst_o.kind = BurstError;
      end
    end
  end

  assign clear = accept_i && last;

  // packet state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q   <= 1'b0;
      prefix_count_q <= 2'd0;
      length_accum_q <= 32'd0;
      payload_left_q <= 32'd0;
      first_unit_q   <= 1'b1;
      error_seen_q   <= 1'b0;
    end else if (clear) begin
      in_payload_q   <= 1'b0;
      prefix_count_q <= 2'd0;
      length_accum_q <= 32'd0;
      payload_left_q <= 32'd0;
      first_unit_q   <= 1'b1;
      error_seen_q   <= 1'b0;
    end else if (accept_i) begin
      in_payload_q   <= in_payload_d;
      prefix_count_q <= prefix_count_d;
      length_accum_q <= length_accum_d;
      payload_left_q <= payload_left_d;
      first_unit_q   <= first_unit_d;
      error_seen_q   <= error_seen_d;
    end
  end

`ifndef SYNTH
  // a swallowed packet never counts payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    error_seen_q |-> (!in_payload_q && payload_left_q == 32'd0))
    else $error("error state with payload pending");

  // while in payload there is always at least one byte left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> (payload_left_q != 32'd0))
    else $error("payload state with zero bytes left");
`endif

endmodule

>>> rtl/lpsc_emit.sv
// lpsc_emit: two-entry burst queue and beat sequencer driving the output channel
// depends on lpsc_pkg
`timescale 1ns / 1ps

module lpsc_emit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  lpsc_pkg::lpsc_burst_t burst_i,
  output logic                  full_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output lpsc_pkg::lpsc_out_t   out_data_o
);
  import lpsc_pkg::*;

  lpsc_burst_t mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q, count_d;
  logic [1:0]  beat_q;
  logic [1:0]  beat_max;
  logic        last_beat;
  logic        pop;
  lpsc_burst_t head;

  assign head        = mem_q[rd_ptr_q];
  assign full_o      = (count_q == 2'd2);
  assign out_valid_o = (count_q != 2'd0);

  // beats per burst, minus one
  always_comb begin
    unique case (head.kind)
      BurstPayload: beat_max = 2'd0;
      BurstError:   beat_max = 2'd0;
      BurstStart3:  beat_max = 2'd2;
      BurstStart4:  beat_max = 2'd3;
      default:      beat_max = 2'd0;
    endcase
  end

  assign last_beat = (beat_q == beat_max);
  assign pop       = out_valid_o && out_ready_i && last_beat;

  // output word from the head burst
  always_comb begin
    out_data_o.run_last     = last_beat;
    out_data_o.packet_end   = last_beat && head.pkt_last;
    out_data_o.packet_error = (head.kind == BurstError);
    unique case (head.kind)
      BurstPayload: out_data_o.out_byte = head.data;
      BurstError:   out_data_o.out_byte = ErrorByte;
      BurstStart3,
      BurstStart4:  out_data_o.out_byte = last_beat ? StartOneByte : StartZeroByte;
      default:      out_data_o.out_byte = ErrorByte;
    endcase
  end

  // occupancy
  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop) begin
      count_d = count_q - 2'd1;
    end
  end

  // queue pointers and beat counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
      beat_q   <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
        beat_q   <= 2'd0;
      end else if (out_valid_o && out_ready_i) begin
        beat_q <= beat_q + 2'd1;
      end
    end
  end

  // burst storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= burst_i;
    end
  end

`ifndef SYNTH
  // a burst never arrives while the queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != 2'd2))
    else $error("burst pushed into full queue");

  // beat counter rests at zero while nothing is queued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0) |-> (beat_q == 2'd0))
    else $error("beat counter moved with empty queue");
`endif

endmodule

>>> dv/length_prefixed_to_start_code_nal_test.sv
// length_prefixed_to_start_code_nal_test: self-checking bench for the prefix to start-code converter
// depends on lpsc_pkg and length_prefixed_to_start_code_nal; directed table, then random packets
`timescale 1ns / 1ps

module length_prefixed_to_start_code_nal_test;
  import lpsc_pkg::*;

  localparam int WatchdogCycles = 2000;
  localparam int DrainCycles    = 20;

  // one row of the directed table: a length write or an input word
  typedef struct packed {
    logic                 is_len;
    logic [LenBytesW-1:0] len_val;
    lpsc_in_t             word;
    logic                 chk_on;
    logic [2:0]           chk_n;
    lpsc_out_t [3:0]      chk_words;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  lpsc_in_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  lpsc_out_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [LenBytesW-1:0] cfg_data;

  // converter model state
  logic [LenBytesW-1:0] pred_len;
  logic                 in_body;
  logic [1:0]           hdr_cnt;
  logic [31:0]          hdr_len;
  logic [31:0]          body_left;
  logic                 first_nal;
  logic                 drop_pkt;

  lpsc_out_t step_words[$];
  lpsc_out_t annexb_q[$];
  stim_row_t dir_rows[$];

  // typed expectation for the word currently on the input
  logic            chk_on;
  logic [2:0]      chk_n;
  lpsc_out_t [3:0] chk_words;

  int                   mismatch_cnt;
  int                   items_sent;
  int                   src_gap_pct;
  int                   sink_stall_pct;
  logic [LenBytesW-1:0] cur_len;

  length_prefixed_to_start_code_nal dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic lpsc_out_t mk_word(input logic [7:0] b, input logic rl, input logic pe,
                                        input logic er);
    lpsc_out_t r;
    r.out_byte     = b;
    r.run_last     = rl;
    r.packet_end   = pe;
    r.packet_error = er;
    return r;
  endfunction

  function automatic void start_new_packet();
    in_body   = 1'b0;
    hdr_cnt   = 2'd0;
    hdr_len   = 32'd0;
    body_left = 32'd0;
    first_nal = 1'b1;
    drop_pkt  = 1'b0;
  endfunction

  // broken packet: error word on its last byte, otherwise swallow until then
  function automatic void abort_packet(input logic last);
    if (last) begin
      step_words.insert(step_words.size(), mk_word(ErrorByte, 1'b1, 1'b1, 1'b1));
      start_new_packet();
    end else begin
      in_body   = 1'b0;
      hdr_cnt   = 2'd0;
      hdr_len   = 32'd0;
      body_left = 32'd0;
      drop_pkt  = 1'b1;
    end
  endfunction

  // words the converter should emit for one accepted input word
  function automatic void convert_word(input lpsc_in_t w);
    logic [2:0] lb;
    logic [2:0] cnt;
    step_words.delete();
    lb = pred_len;
    if (lb == 3'd0) lb = LenBytesMin;
    if (lb > LenBytesMax) lb = LenBytesMax;
    if (drop_pkt) begin
      abort_packet(w.packet_last);
      return;
    end
    // payload byte passes through
    if (in_body) begin
      body_left = body_left - 32'd1;
      if (w.packet_last && body_left != 32'd0) begin
        abort_packet(1'b1);
        return;
      end
      step_words.insert(step_words.size(), mk_word(w.in_byte, 1'b1, w.packet_last, 1'b0));
      if (body_left == 32'd0) begin
        in_body = 1'b0;
        hdr_cnt = 2'd0;
        hdr_len = 32'd0;
      end
      if (w.packet_last) start_new_packet();
      return;
    end
    // prefix byte, big endian
    hdr_len = {hdr_len[23:0], w.in_byte};
    cnt = {1'b0, hdr_cnt} + 3'd1;
    if (cnt < lb) begin
      hdr_cnt = cnt[1:0];
      if (w.packet_last) abort_packet(1'b1);
      return;
    end
    if ((lb == LenBytesMax && hdr_len[31]) || (hdr_len != 32'd0 && w.packet_last)) begin
      abort_packet(w.packet_last);
      return;
    end
    // start code replaces the prefix
    if (first_nal)
      step_words.insert(step_words.size(), mk_word(StartZeroByte, 1'b0, 1'b0, 1'b0));
    step_words.insert(step_words.size(), mk_word(StartZeroByte, 1'b0, 1'b0, 1'b0));
    step_words.insert(step_words.size(), mk_word(StartZeroByte, 1'b0, 1'b0, 1'b0));
    step_words.insert(step_words.size(), mk_word(StartOneByte, 1'b1, w.packet_last, 1'b0));
    first_nal = 1'b0;
    hdr_cnt   = 2'd0;
    if (hdr_len != 32'd0) begin
      in_body   = 1'b1;
      body_left = hdr_len;
    end
    hdr_len = 32'd0;
    if (w.packet_last) start_new_packet();
  endfunction

  // track accepted words, predict, and check output words
  always @(posedge clk) begin : monitor
    int k;
    lpsc_out_t exp_w;
    if (!rst_n) begin
      pred_len = LenBytesReset;
      start_new_packet();
    end else begin
      if (cfg_valid && cfg_ready) pred_len = cfg_data;
      if (in_valid && in_ready) begin
        convert_word(in_data);
        if (chk_on) begin
          for (k = 0; k < chk_n; k++) annexb_q.insert(annexb_q.size(), chk_words[k]);
        end else begin
          foreach (step_words[j]) annexb_q.insert(annexb_q.size(), step_words[j]);
        end
      end
      if (out_valid && out_ready) begin
        if (annexb_q.size() == 0) begin
          $display("%0t: expected no word, got byte=%h rl=%b end=%b err=%b", $time,
                   out_data.out_byte, out_data.run_last, out_data.packet_end,
                   out_data.packet_error);
          mismatch_cnt++;
        end else begin
          exp_w = annexb_q.pop_front();
          if (out_data !== exp_w) begin
            $display("%0t: expected byte=%h rl=%b end=%b err=%b, got byte=%h rl=%b end=%b err=%b",
                     $time, exp_w.out_byte, exp_w.run_last, exp_w.packet_end,
                     exp_w.packet_error, out_data.out_byte, out_data.run_last,
                     out_data.packet_end, out_data.packet_error);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // watchdog: cycles with no handshake on any channel
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogCycles) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // hold one word on the input until it is taken
  task automatic drive_word(input lpsc_in_t w, input logic on, input logic [2:0] n,
                            input lpsc_out_t [3:0] words);
    @(negedge clk);
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    chk_on    = on;
    chk_n     = n;
    chk_words = words;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // length register write, only once the converter has gone quiet
  task automatic write_len_bytes(input logic [LenBytesW-1:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (annexb_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_len = v;
  endtask

  function automatic void add_item(input logic [7:0] b, input logic last);
    stim_row_t r;
    r = '0;
    r.word.in_byte     = b;
    r.word.packet_last = last;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void add_checked(input logic [7:0] b, input logic last, input logic [2:0] n,
                                      input lpsc_out_t w0, input lpsc_out_t w1,
                                      input lpsc_out_t w2, input lpsc_out_t w3);
    stim_row_t r;
    r = '0;
    r.word.in_byte     = b;
    r.word.packet_last = last;
    r.chk_on           = 1'b1;
    r.chk_n            = n;
    r.chk_words        = {w3, w2, w1, w0};
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void add_len(input logic [LenBytesW-1:0] v);
    stim_row_t r;
    r = '0;
    r.is_len  = 1'b1;
    r.len_val = v;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // one random packet: mostly well formed, some cut short, some pure noise
  task automatic send_packet();
    logic [7:0]  pkt[$];
    logic [31:0] len;
    lpsc_in_t    w;
    int          lb;
    int          units;
    int          cut;
    lb = (cur_len == 3'd0) ? 1 : ((cur_len > LenBytesMax) ? 4 : cur_len);
    units = $urandom_range(1, 3);
    repeat (units) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 5);
      if (lb == 4 && $urandom_range(24) == 0) len[31] = 1'b1;
      for (int i = lb - 1; i >= 0; i--) pkt.insert(pkt.size(), len[8*i +: 8]);
      if (!len[31]) repeat (len) pkt.insert(pkt.size(), 8'($urandom_range(255)));
    end
    case ($urandom_range(9))
      0: begin
        cut = $urandom_range(1, pkt.size());
        while (pkt.size() > cut) void'(pkt.pop_back());
      end
      1: begin
        pkt.delete();
        repeat ($urandom_range(1, 10)) pkt.insert(pkt.size(), 8'($urandom_range(255)));
      end
      default: ;
    endcase
    foreach (pkt[i]) begin
      w.in_byte     = pkt[i];
      w.packet_last = (i == pkt.size() - 1);
      drive_word(w, 1'b0, 3'd0, '0);
    end
  endtask

  // stimulus
  initial begin : stimulus
    lpsc_out_t zb;
    lpsc_out_t sc1;
    lpsc_out_t err_w;
    int        pkt_cnt;
    int        phase_end;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    chk_on         = 1'b0;
    chk_n          = '0;
    chk_words      = '0;
    mismatch_cnt   = 0;
    items_sent     = 0;
    src_gap_pct    = 12;
    sink_stall_pct = 80;
    cur_len        = LenBytesReset;
    pkt_cnt        = 0;
    zb    = mk_word(StartZeroByte, 1'b0, 1'b0, 1'b0);
    sc1   = mk_word(StartOneByte, 1'b1, 1'b0, 1'b0);
    err_w = mk_word(ErrorByte, 1'b1, 1'b1, 1'b1);

    // after reset: four-byte prefix, long start code on the first unit
    add_item(8'h00, 1'b0);
    add_item(8'h00, 1'b0);
    add_item(8'h00, 1'b0);
    add_checked(8'h02, 1'b0, 3'd4, zb, zb, zb, sc1);
    add_checked(8'hFF, 1'b0, 3'd1, mk_word(8'hFF, 1'b1, 1'b0, 1'b0), '0, '0, '0);
    add_checked(8'h80, 1'b0, 3'd1, mk_word(8'h80, 1'b1, 1'b0, 1'b0), '0, '0, '0);
    // zero-length unit whose prefix closes the packet
    add_item(8'h00, 1'b0);
    add_item(8'h00, 1'b0);
    add_item(8'h00, 1'b0);
    add_checked(8'h00, 1'b1, 3'd3, zb, zb, mk_word(StartOneByte, 1'b1, 1'b1, 1'b0), '0);
    // four-byte length with the top bit set, rest swallowed
    add_item(8'h80, 1'b0);
    add_item(8'h00, 1'b0);
    add_item(8'h00, 1'b0);
    add_checked(8'h00, 1'b0, 3'd0, '0, '0, '0, '0);
    add_checked(8'h55, 1'b1, 3'd1, err_w, '0, '0, '0);
    // register zero acts as one; packet ends inside the payload
    add_len(3'd0);
    add_item(8'h02, 1'b0);
    add_checked(8'h11, 1'b1, 3'd1, err_w, '0, '0, '0);
    // nonzero length on the last byte
    add_checked(8'h05, 1'b1, 3'd1, err_w, '0, '0, '0);
    // register seven acts as four; packet ends inside the prefix
    add_len(3'd7);
    add_item(8'h00, 1'b0);
    add_checked(8'h00, 1'b1, 3'd1, err_w, '0, '0, '0);
    // length register changed in the middle of a prefix
    add_len(3'd2);
    add_item(8'h00, 1'b0);
    add_item(8'h01, 1'b0);
    add_item(8'h7E, 1'b0);
    add_item(8'h00, 1'b0);
    add_len(3'd1);
    add_item(8'h01, 1'b0);
    add_item(8'hC3, 1'b1);

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_len)
        write_len_bytes(dir_rows[i].len_val);
      else
        drive_word(dir_rows[i].word, dir_rows[i].chk_on, dir_rows[i].chk_n,
                   dir_rows[i].chk_words);
    end

    // random packets under three idling patterns
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin src_gap_pct = 12; sink_stall_pct = 80; end
        1: begin src_gap_pct = 80; sink_stall_pct = 12; end
        default: begin src_gap_pct = 0; sink_stall_pct = 0; end
      endcase
      phase_end = items_sent + 142;
      while (items_sent < phase_end) begin
        if (pkt_cnt % 3 == 0) write_len_bytes(3'($urandom_range(7)));
        send_packet();
        pkt_cnt++;
      end
    end

    // drain
    @(negedge clk);
    in_valid <= 1'b0;
    while (annexb_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_cnt == 0 && annexb_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
rtl/lpsc_pkg.sv
rtl/lpsc_parse.sv
rtl/lpsc_emit.sv
rtl/length_prefixed_to_start_code_nal.sv
dv/length_prefixed_to_start_code_nal_test.sv
